// File: rtl/core/wsd_pkg.sv
// Shared types and constants of the WebSocket frame deframer.
`timescale 1ns / 1ps

package wsd_pkg;

  typedef enum logic [3:0] {
    PH_HDR0 = 4'b0001,
    PH_HDR1 = 4'b0010,
    PH_EXT  = 4'b0100,
    PH_PAY  = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_END    = 2'd1,
    KIND_CLOSED = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [2:0] EXT16_COUNT = 3'd1;
  localparam logic [2:0] EXT64_COUNT = 3'd7;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    logic       message_binary;
    logic       last_of_message;
  } result_t;

endpackage

// File: rtl/core/wsd_parser.sv
// Frame header and payload parser: state registers and per-word next-state logic.
`timescale 1ns / 1ps

module wsd_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  logic [7:0]      rx_byte_i,
  output logic            res_valid_o,
  output wsd_pkg::result_t res_o,
  output logic            halted_o
);
  import wsd_pkg::*;

  phase_e      phase_q, phase_d;
  logic        fin_q, fin_d;
  logic [3:0]  op_q, op_d;
  logic        mib_q, mib_d;
  logic [63:0] rem_q, rem_d;
  logic [2:0]  lbc_q, lbc_d;
  logic        halted_q, halted_d;

  logic        op_close, op_skip;
  logic [6:0]  len7;
  logic [63:0] rem_shift, rem_dec, rem_begin;
  logic        pay_done;
  logic        begin_now;
  logic        new_op_data;

  always_comb begin
    op_close    = (op_q == OP_CLOSE);
    op_skip     = (op_q == OP_PING) || (op_q == OP_PONG);
    len7        = rx_byte_i[6:0];
    rem_shift   = {rem_q[55:0], rx_byte_i};
    rem_dec     = rem_q - 64'd1;
    pay_done    = (rem_dec == 64'd0);
    new_op_data = (rx_byte_i[3:0] != OP_CONT) && (rx_byte_i[3:0] != OP_CLOSE) &&
                  (rx_byte_i[3:0] != OP_PING) && (rx_byte_i[3:0] != OP_PONG);
  end

  always_comb begin
    phase_d     = phase_q;
    fin_d       = fin_q;
    op_d        = op_q;
    mib_d       = mib_q;
    rem_d       = rem_q;
    lbc_d       = lbc_q;
    halted_d    = halted_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_DATA, data_byte: 8'd0, message_binary: 1'b0,
                    last_of_message: 1'b0};
    begin_now   = 1'b0;
    rem_begin   = 64'd0;

    if (fire_i && !halted_q) begin
      case (phase_q)
        PH_HDR1: begin
          if (rx_byte_i[7]) begin
            halted_d    = 1'b1;
            res_valid_o = 1'b1;
            res_o.kind  = KIND_ERROR;
          end else if (len7 == LEN_EXT16) begin
            rem_d   = 64'd0;
            lbc_d   = EXT16_COUNT;
            phase_d = PH_EXT;
          end else if (len7 == LEN_EXT64) begin
            rem_d   = 64'd0;
            lbc_d   = EXT64_COUNT;
            phase_d = PH_EXT;
          end else begin
            begin_now = 1'b1;
            rem_begin = {57'd0, len7};
          end
        end
        PH_EXT: begin
          if (lbc_q == 3'd0) begin
            begin_now = 1'b1;
            rem_begin = rem_shift;
          end else begin
            rem_d = rem_shift;
            lbc_d = lbc_q - 3'd1;
          end
        end
        PH_PAY: begin
          rem_d = rem_dec;
          if (pay_done) begin
            phase_d = PH_HDR0;
          end
          if (op_close) begin
            if (pay_done) begin
              halted_d    = 1'b1;
              res_valid_o = 1'b1;
              res_o.kind  = KIND_CLOSED;
            end
          end else if (!op_skip) begin
            res_valid_o           = 1'b1;
            res_o.kind            = KIND_DATA;
            res_o.data_byte       = rx_byte_i;
            res_o.message_binary  = mib_q;
            res_o.last_of_message = fin_q && pay_done;
            if (fin_q && pay_done) begin
              mib_d = 1'b0;
            end
          end
        end
        default: begin
          fin_d = rx_byte_i[7];
          op_d  = rx_byte_i[3:0];
          if (new_op_data) begin
            mib_d = (rx_byte_i[3:0] == OP_BINARY);
          end
          phase_d = PH_HDR1;
        end
      endcase

      if (begin_now) begin
        rem_d = rem_begin;
        if (rem_begin == 64'd0) begin
          phase_d = PH_HDR0;
          if (op_close) begin
            halted_d    = 1'b1;
            res_valid_o = 1'b1;
            res_o.kind  = KIND_CLOSED;
          end else if (!op_skip && fin_q) begin
            res_valid_o           = 1'b1;
            res_o.kind            = KIND_END;
            res_o.message_binary  = mib_q;
            res_o.last_of_message = 1'b1;
            mib_d                 = 1'b0;
          end
        end else begin
          phase_d = PH_PAY;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      fin_q    <= 1'b0;
      op_q     <= 4'd0;
      mib_q    <= 1'b0;
      rem_q    <= 64'd0;
      lbc_q    <= 3'd0;
      halted_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      fin_q    <= fin_d;
      op_q     <= op_d;
      mib_q    <= mib_d;
      rem_q    <= rem_d;
      lbc_q    <= lbc_d;
      halted_q <= halted_d;
    end
  end

  assign halted_o = halted_q;

  a_halt_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt released without reset");

  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> !res_valid_o)
    else $error("result emitted while halted");

  a_term_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.kind == KIND_CLOSED || res_o.kind == KIND_ERROR)) |=> halted_q)
    else $error("close or error did not halt");

  a_pay_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAY) |-> (rem_q != 64'd0))
    else $error("payload phase with zero bytes left");

endmodule

// File: rtl/core/wsd_out_fifo.sv
// Two-entry result buffer that decouples the parser from the output stall.
`timescale 1ns / 1ps

module wsd_out_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  wsd_pkg::result_t push_data_i,
  output logic             space_o,
  output logic             valid_o,
  input  logic             pop_i,
  output wsd_pkg::result_t data_o
);
  import wsd_pkg::*;

  result_t     mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        do_pop;

  always_comb begin
    do_pop   = pop_i && (count_q != 2'd0);
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign space_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> space_o)
    else $error("push into full buffer");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("buffer count out of range");

  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
    else $error("pointers disagree with count");

endmodule

// File: rtl/core/websocket_frame_deframer_core.sv
// Top level of the WebSocket server-to-client frame deframer.
// Usage:
//   The slave stream carries one received byte per word on s_axis_tdata_i.
//   The master stream gives payload bytes on m_axis_tdata_o with the result
//   kind and message type on m_axis_tuser_o and tlast on the final byte or
//   the end marker of a message. Header bytes give no data word; ping and
//   pong bytes give no word. A close frame gives one word of kind closed, a
//   masked frame one word of kind protocol error; after either, every input
//   word is accepted and dropped until reset.
//   An accepted word is held in the input register and parsed once the
//   buffer has space; its result is registered into the buffer, which
//   drives m_axis_tvalid_o.
//   Throughput: one word per cycle while the buffer has space; the parse
//   step with its 64-bit length decrement is combinational.
//   Reset clears the parser to expect a frame header and empties the
//   two-entry result buffer. When the receiver stalls, the buffer fills and
//   s_axis_tready_o drops once the buffer and the input register are full.
`timescale 1ns / 1ps

module websocket_frame_deframer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] rx_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] data_byte
  output logic [2:0] m_axis_tuser_o,   // [1:0] kind, [2] message_binary
  output logic       m_axis_tlast_o    // last_of_message
);
  import wsd_pkg::*;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_take;
  logic       advance;
  logic       fifo_space;
  logic       res_valid;
  result_t    res;
  result_t    out_res;
  logic       halted;

  assign advance         = in_valid_q && fifo_space;
  assign s_axis_tready_o = !in_valid_q || fifo_space;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;
  assign in_valid_d      = in_take || (in_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  wsd_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (advance),
    .rx_byte_i  (in_byte_q),
    .res_valid_o(res_valid),
    .res_o      (res),
    .halted_o   (halted)
  );

  wsd_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_data_i(res),
    .space_o    (fifo_space),
    .valid_o    (m_axis_tvalid_o),
    .pop_i      (m_axis_tready_i),
    .data_o     (out_res)
  );

  assign m_axis_tdata_o = out_res.data_byte;
  assign m_axis_tuser_o = {out_res.message_binary, out_res.kind};
  assign m_axis_tlast_o = out_res.last_of_message;

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !fifo_space) |=> (in_valid_q && $stable(in_byte_q)))
    else $error("input word lost during stall");

  a_push_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> advance)
    else $error("result without an input word");

  a_halted_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (halted && !m_axis_tvalid_o) |=> !m_axis_tvalid_o)
    else $error("output after halt drained");

endmodule

// File: sim/tb_websocket_frame_deframer_core.sv
// Self-checking testbench of the WebSocket frame deframer core on directed and random byte streams.
`timescale 1ns / 1ps

module tb_websocket_frame_deframer_core;
  import wsd_pkg::*;

  typedef enum logic [1:0] {
    EXP_MODEL,
    EXP_NONE,
    EXP_WORD
  } exp_e;

  typedef struct packed {
    logic [7:0] rx;
    exp_e       mode;
    result_t    want;
  } row_t;

  localparam int NUM_RANDOM = 1450;
  localparam int NUM_DIRECTED = 30;

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid_i;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i;
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i;
  logic [7:0] m_axis_tdata_o;
  logic [2:0] m_axis_tuser_o;
  logic       m_axis_tlast_o;

  websocket_frame_deframer_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  phase_e      rx_phase = PH_HDR0;
  logic        rx_fin = 1'b0;
  logic [3:0]  rx_opcode = OP_CONT;
  logic        msg_binary = 1'b0;
  logic [63:0] len_left = '0;
  logic [2:0]  ext_left = '0;
  logic        link_down = 1'b0;

  result_t expected_words[$];
  int      idle_pct = 38;
  int      n_bytes = 0;
  int      n_frames = 0;
  int      n_words = 0;
  int      n_fail = 0;
  string   ending_name = "none";
  result_t got_w;
  result_t want_w;

  row_t dir_rows [NUM_DIRECTED] = '{
    '{8'h02, EXP_NONE,  '0},
    '{8'h01, EXP_NONE,  '0},
    '{8'hFF, EXP_WORD,  '{KIND_DATA, 8'hFF, 1'b1, 1'b0}},
    '{8'h89, EXP_NONE,  '0},
    '{8'h02, EXP_NONE,  '0},
    '{8'h00, EXP_NONE,  '0},
    '{8'hFF, EXP_NONE,  '0},
    '{8'h80, EXP_NONE,  '0},
    '{8'h00, EXP_WORD,  '{KIND_END, 8'h00, 1'b1, 1'b1}},
    '{8'h81, EXP_NONE,  '0},
    '{8'h00, EXP_WORD,  '{KIND_END, 8'h00, 1'b0, 1'b1}},
    '{8'h00, EXP_NONE,  '0},
    '{8'h7E, EXP_NONE,  '0},
    '{8'h00, EXP_NONE,  '0},
    '{8'h02, EXP_NONE,  '0},
    '{8'hA5, EXP_MODEL, '0},
    '{8'h3C, EXP_MODEL, '0},
    '{8'h8A, EXP_NONE,  '0},
    '{8'h00, EXP_NONE,  '0},
    '{8'hF3, EXP_NONE,  '0},
    '{8'h7F, EXP_NONE,  '0},
    '{8'h00, EXP_NONE,  '0},
    '{8'h00, EXP_NONE,  '0},
    '{8'h00, EXP_NONE,  '0},
    '{8'h00, EXP_NONE,  '0},
    '{8'h00, EXP_NONE,  '0},
    '{8'h00, EXP_NONE,  '0},
    '{8'h00, EXP_NONE,  '0},
    '{8'h01, EXP_NONE,  '0},
    '{8'h80, EXP_WORD,  '{KIND_DATA, 8'h80, 1'b0, 1'b1}}
  };

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("websocket_frame_deframer_core test failed");
    $finish;
  end

  task automatic open_payload(output bit got, output result_t r);
    got = 1'b0;
    r = '0;
    rx_phase = PH_HDR0;
    if (len_left != 0) begin
      rx_phase = PH_PAY;
    end else if (rx_opcode == OP_CLOSE) begin
      link_down = 1'b1;
      got = 1'b1;
      r.kind = KIND_CLOSED;
    end else if (rx_opcode != OP_PING && rx_opcode != OP_PONG && rx_fin) begin
      got = 1'b1;
      r.kind = KIND_END;
      r.message_binary = msg_binary;
      r.last_of_message = 1'b1;
      msg_binary = 1'b0;
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b, output bit got, output result_t r);
    logic done;
    got = 1'b0;
    r = '0;
    if (link_down) return;
    case (rx_phase)
      PH_HDR1: begin
        len_left = '0;
        if (b[7]) begin
          link_down = 1'b1;
          got = 1'b1;
          r.kind = KIND_ERROR;
        end else if (b[6:0] == LEN_EXT16) begin
          ext_left = EXT16_COUNT;
          rx_phase = PH_EXT;
        end else if (b[6:0] == LEN_EXT64) begin
          ext_left = EXT64_COUNT;
          rx_phase = PH_EXT;
        end else begin
          len_left = {57'd0, b[6:0]};
          open_payload(got, r);
        end
      end
      PH_EXT: begin
        len_left = {len_left[55:0], b};
        if (ext_left == 0) open_payload(got, r);
        else ext_left = ext_left - 3'd1;
      end
      PH_PAY: begin
        len_left = len_left - 64'd1;
        done = (len_left == 0);
        if (done) rx_phase = PH_HDR0;
        if (rx_opcode == OP_CLOSE) begin
          if (done) begin
            link_down = 1'b1;
            got = 1'b1;
            r.kind = KIND_CLOSED;
          end
        end else if (rx_opcode != OP_PING && rx_opcode != OP_PONG) begin
          got = 1'b1;
          r.kind = KIND_DATA;
          r.data_byte = b;
          r.message_binary = msg_binary;
          r.last_of_message = rx_fin && done;
          if (rx_fin && done) msg_binary = 1'b0;
        end
      end
      default: begin
        rx_fin = b[7];
        rx_opcode = b[3:0];
        if (rx_opcode != OP_CONT && rx_opcode != OP_CLOSE &&
            rx_opcode != OP_PING && rx_opcode != OP_PONG) begin
          msg_binary = (rx_opcode == OP_BINARY);
        end
        rx_phase = PH_HDR1;
      end
    endcase
  endtask

  task automatic push_byte(input logic [7:0] b, input exp_e mode = EXP_MODEL,
                           input result_t want = '0);
    bit      got;
    result_t r;
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      s_axis_tdata_i = 8'($urandom);
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i = b;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    deframe_byte(b, got, r);
    if (mode == EXP_WORD) expected_words.push_back(want);
    else if (mode == EXP_MODEL && got) expected_words.push_back(r);
    n_bytes++;
  endtask

  task automatic note_mismatch(input string what, input result_t want, input result_t got);
    if (n_fail < 10) begin
      $display("%s: expected kind %0d data %h bin %b last %b, got kind %0d data %h bin %b last %b",
               what, want.kind, want.data_byte, want.message_binary, want.last_of_message,
               got.kind, got.data_byte, got.message_binary, got.last_of_message);
    end
    n_fail++;
  endtask

  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready_i = ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_w.kind = kind_e'(m_axis_tuser_o[1:0]);
      got_w.data_byte = m_axis_tdata_o;
      got_w.message_binary = m_axis_tuser_o[2];
      got_w.last_of_message = m_axis_tlast_o;
      n_words++;
      if (expected_words.size() == 0) begin
        note_mismatch("unexpected word", '0, got_w);
      end else begin
        want_w = expected_words.pop_front();
        if (got_w !== want_w) note_mismatch("word mismatch", want_w, got_w);
      end
    end
  end

  initial begin
    logic [3:0]  op;
    logic [7:0]  hdr;
    int unsigned len;
    int unsigned pick;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = 8'h00;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) push_byte(dir_rows[i].rx, dir_rows[i].mode, dir_rows[i].want);

    while (n_bytes < NUM_DIRECTED + NUM_RANDOM) begin
      idle_pct = (n_bytes > 500 && n_bytes < 800) ? 0 : 38;
      pick = $urandom_range(99);
      if (pick < 35) op = OP_CONT;
      else if (pick < 57) op = OP_BINARY ^ 4'h3;
      else if (pick < 79) op = OP_BINARY;
      else if (pick < 87) op = OP_PING;
      else if (pick < 95) op = OP_PONG;
      else op = 4'($urandom);
      if (op == OP_CLOSE) op = OP_BINARY;
      hdr = {1'($urandom), 3'($urandom), op};
      push_byte(hdr);
      pick = $urandom_range(99);
      if (pick < 80) begin
        len = (pick < 70) ? $urandom_range(0, 12) : $urandom_range(13, 125);
        push_byte({1'b0, 7'(len)});
      end else if (pick < 92) begin
        len = (pick < 90) ? $urandom_range(0, 40) : $urandom_range(126, 300);
        push_byte({1'b0, LEN_EXT16});
        push_byte(8'(len >> 8));
        push_byte(8'(len));
      end else begin
        len = $urandom_range(0, 20);
        push_byte({1'b0, LEN_EXT64});
        for (int k = 7; k >= 0; k--) push_byte(8'(64'(len) >> (8 * k)));
      end
      repeat (len) push_byte(8'($urandom));
      n_frames++;
    end

    idle_pct = 38;
    case ($urandom_range(2))
      0: begin
        ending_name = "close frame";
        push_byte({1'($urandom), 3'($urandom), OP_CLOSE});
        len = $urandom_range(0, 3);
        push_byte({1'b0, 7'(len)});
        repeat (len) push_byte(8'($urandom));
        repeat (8) push_byte(8'($urandom));
      end
      1: begin
        ending_name = "masked frame";
        push_byte(8'($urandom));
        push_byte({1'b1, 7'($urandom)});
        repeat (8) push_byte(8'($urandom));
      end
      default: begin
        ending_name = "frame with a huge 64-bit length";
        push_byte({1'b1, 3'b000, OP_BINARY});
        push_byte({1'b0, LEN_EXT64});
        repeat (8) push_byte(8'($urandom));
        repeat (6) push_byte(8'($urandom));
      end
    endcase
    n_frames++;

    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("fed %0d stream bytes in %0d frames, checked %0d result words, %0d mismatches",
             n_bytes, n_frames, n_words, n_fail);
    $display("stream ended with a %s", ending_name);
    if (n_fail == 0 && expected_words.size() == 0) begin
      $display("websocket_frame_deframer_core test passed");
    end else begin
      $display("websocket_frame_deframer_core test failed");
    end
    $finish;
  end

endmodule
